// ===== hdl/sorted_set_insert_top_macros.svh =====
// Assertion macros for the sorted set insert block.
// Included by the modules that carry concurrent checks; clocked on i_clk.
`ifndef SORTED_SET_INSERT_TOP_MACROS_SVH
`define SORTED_SET_INSERT_TOP_MACROS_SVH

// Plain property, checked outside reset.
`define SSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define SSI_ASSERT_IMPL(label, ante, cons, msg) \
    `SSI_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication, checked outside reset.
`define SSI_ASSERT_NEXT(label, ante, cons, msg) \
    `SSI_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== hdl/ssi_pkg.sv =====
// Shared types and constants for the sorted set insert block.
// Used by the controller, the datapath and the top level.
package ssi_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 31;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int FILL_W   = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic found;
        logic mark_pos;
        logic mark_full;
        logic inc;
        logic shift_rd;
        logic shift_wr;
        logic put;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic eq;
        logic gt;
        logic full;
        logic at_pos;
        logic out_busy;
    } t_stat;

endpackage

// ===== hdl/ssi_ctrl.sv =====
// Sequencer for the sorted set insert block: scan, shift, write, report.
// Depends on ssi_pkg for the state, command and status types.
module ssi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ssi_pkg::t_stat i_stat,
    output ssi_pkg::t_cmd  o_cmd
);

    ssi_pkg::t_state r_state;
    ssi_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ssi_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ssi_pkg::S_READ;
                end
            end
            ssi_pkg::S_READ: begin
                if (i_stat.scan_end) begin
                    // value lies above every entry: append, or report full
                    if (i_stat.full) begin
                        o_cmd.mark_full = 1'b1;
                        n_state         = ssi_pkg::S_FINISH;
                    end else begin
                        o_cmd.mark_pos = 1'b1;
                        n_state        = ssi_pkg::S_SHIFT_RD;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ssi_pkg::S_CMP;
                end
            end
            ssi_pkg::S_CMP: begin
                if (i_stat.eq) begin
                    o_cmd.found = 1'b1;
                    n_state     = ssi_pkg::S_FINISH;
                end else if (i_stat.gt) begin
                    // entries ascend, so the first greater entry ends the search
                    if (i_stat.full) begin
                        o_cmd.mark_full = 1'b1;
                        n_state         = ssi_pkg::S_FINISH;
                    end else begin
                        o_cmd.mark_pos = 1'b1;
                        n_state        = ssi_pkg::S_SHIFT_RD;
                    end
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = ssi_pkg::S_READ;
                end
            end
            ssi_pkg::S_SHIFT_RD: begin
                if (i_stat.at_pos) begin
                    n_state = ssi_pkg::S_PUT;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = ssi_pkg::S_SHIFT_WR;
                end
            end
            ssi_pkg::S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = ssi_pkg::S_SHIFT_RD;
            end
            ssi_pkg::S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = ssi_pkg::S_FINISH;
            end
            ssi_pkg::S_FINISH: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ssi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssi_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ssi_dpath.sv =====
// Datapath for the sorted set insert block: entry memory, scan index, count
// and the output register. Depends on ssi_pkg and the assertion macro header.
`include "sorted_set_insert_top_macros.svh"

module ssi_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssi_pkg::t_cmd                 i_cmd,
    output ssi_pkg::t_stat                o_stat,
    input  logic [ssi_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ssi_pkg::STATUS_W-1:0]  o_status,
    output logic [ssi_pkg::POS_W-1:0]     o_position,
    output logic [ssi_pkg::FILL_W-1:0]    o_fill_count
);

    logic [ssi_pkg::VALUE_W-1:0] r_mem [ssi_pkg::CAPACITY];
    logic [ssi_pkg::VALUE_W-1:0] r_rdata;
    logic [ssi_pkg::VALUE_W-1:0] r_value;
    logic [ssi_pkg::CNT_W-1:0]   r_idx;
    logic [ssi_pkg::CNT_W-1:0]   r_count;
    logic [ssi_pkg::IDX_W-1:0]   r_pos;
    logic                        r_found;
    logic                        r_full;
    logic                        r_out_valid;
    ssi_pkg::t_status            r_status;
    logic [ssi_pkg::POS_W-1:0]   r_position;
    logic [ssi_pkg::FILL_W-1:0]  r_fill;

    ssi_pkg::t_status            n_status;
    logic [ssi_pkg::CNT_W-1:0]   w_idx_dec;
    logic [ssi_pkg::IDX_W-1:0]   w_rd_addr;
    logic [31:0]                 w_pos_wide;
    logic [31:0]                 w_cnt_wide;

    assign w_idx_dec  = ssi_pkg::CNT_W'(r_idx - 1'b1);
    assign w_rd_addr  = i_cmd.shift_rd ? w_idx_dec[ssi_pkg::IDX_W-1:0]
                                       : r_idx[ssi_pkg::IDX_W-1:0];
    assign w_pos_wide = i_cmd.found || !r_full ? 32'(r_pos) : 32'd0;
    assign w_cnt_wide = 32'(r_count);

    always_comb begin
        if (r_found) begin
            n_status = ssi_pkg::ST_DUPLICATE;
        end else if (r_full) begin
            n_status = ssi_pkg::ST_FULL;
        end else begin
            n_status = ssi_pkg::ST_INSERTED;
        end
    end

    assign o_stat.scan_end = (r_idx == r_count);
    assign o_stat.eq       = (r_rdata == r_value);
    assign o_stat.gt       = (r_rdata > r_value);
    assign o_stat.full     = (r_count == ssi_pkg::CNT_W'(ssi_pkg::CAPACITY));
    assign o_stat.at_pos   = (r_idx == ssi_pkg::CNT_W'(r_pos));
    assign o_stat.out_busy = r_out_valid && !i_ready;

    // entry memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd || i_cmd.shift_rd) begin
            r_rdata <= r_mem[w_rd_addr];
        end
        if (i_cmd.shift_wr) begin
            r_mem[r_idx[ssi_pkg::IDX_W-1:0]] <= r_rdata;
        end else if (i_cmd.put) begin
            r_mem[r_pos] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_full  <= 1'b0;
        end
        if (i_cmd.inc) begin
            r_idx <= ssi_pkg::CNT_W'(r_idx + 1'b1);
        end
        if (i_cmd.found) begin
            r_found <= 1'b1;
            r_pos   <= r_idx[ssi_pkg::IDX_W-1:0];
        end
        if (i_cmd.mark_full) begin
            r_full <= 1'b1;
        end
        if (i_cmd.mark_pos) begin
            // shifting starts from the top of the filled region
            r_pos <= r_idx[ssi_pkg::IDX_W-1:0];
            r_idx <= r_count;
        end
        if (i_cmd.shift_wr) begin
            r_idx <= w_idx_dec;
        end
        if (i_cmd.emit) begin
            r_status   <= n_status;
            r_position <= r_full && !r_found ? '0 : w_pos_wide[ssi_pkg::POS_W-1:0];
            r_fill     <= w_cnt_wide[ssi_pkg::FILL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.put) begin
                r_count <= ssi_pkg::CNT_W'(r_count + 1'b1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_position   = r_position;
    assign o_fill_count = r_fill;

    `SSI_ASSERT(a_count_bound, r_count <= ssi_pkg::CNT_W'(ssi_pkg::CAPACITY), "count above capacity")
    `SSI_ASSERT_IMPL(a_put_not_full, i_cmd.put, !o_stat.full, "insert into a full store")
    `SSI_ASSERT_NEXT(a_count_only_on_put, !i_cmd.put, $stable(r_count), "count moved without insert")
    `SSI_ASSERT_IMPL(a_emit_slot_free, i_cmd.emit, !o_stat.out_busy, "result overwrote pending result")
    `SSI_ASSERT_IMPL(a_full_report, i_cmd.emit && n_status == ssi_pkg::ST_FULL, o_stat.full,
        "full reported below capacity")

endmodule

// ===== hdl/sorted_set_insert_top.sv =====
// Sorted set insert: ascending store of up to CAPACITY values, one request at a time.
// Each entry compared passes through a read and a compare state, each entry moved up through
// a shift-read and a shift-write state; the entry memory, with one read port and one write port,
// sets the pace, and a result still waiting downstream holds the next one back.
// A new request is taken once the last result is in the output register, even while it waits there.
// Reset clears the count and the handshake state; entries hold no reset value.
module sorted_set_insert_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ssi_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ssi_pkg::STATUS_W-1:0]  o_status,
    output logic [ssi_pkg::POS_W-1:0]     o_position,
    output logic [ssi_pkg::FILL_W-1:0]    o_fill_count
);

    ssi_pkg::t_cmd  w_cmd;
    ssi_pkg::t_stat w_stat;

    ssi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    ssi_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_position   (o_position),
        .o_fill_count (o_fill_count)
    );

endmodule
